// ----- rtl/wspd_pkg.sv -----
// Shared types and constants for the wheel speed PID drive block.
// Used by the register file, the shared multiplier and the top level.
`default_nettype none

package wspd_pkg;

    localparam int CNT_W      = 16;   // encoder delta
    localparam int SPD_W      = 16;   // Q8.8 speed and target
    localparam int ERR_W      = 17;   // Q9.8 error
    localparam int DIFF_W     = 18;   // error minus last error
    localparam int SUM_W      = 32;   // integral
    localparam int GAIN_W     = 10;
    localparam int DUTY_W     = 16;
    localparam int OPA_W      = 33;   // signed multiplier operand
    localparam int OPB_W      = 16;   // unsigned multiplier operand
    localparam int PROD_W     = OPA_W + OPB_W + 1;
    localparam int WHEEL_W    = 2;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_SH    = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P        = 3'd0,
        CFG_GAIN_I        = 3'd1,
        CFG_GAIN_D        = 3'd2,
        CFG_SPEED_SCALE   = 3'd3,
        CFG_POLARITY_MASK = 3'd4,
        CFG_DUTY_LIMIT    = 3'd5,
        CFG_BRAKE_LEVEL   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [15:0]       speed_scale;
        logic [MASK_W-1:0] polarity_mask;
        logic [DUTY_W-1:0] duty_limit;
        logic [DUTY_W-1:0] brake_level;
    } cfg_regs_t;

    localparam logic [GAIN_W-1:0] GAIN_P_RST        = 10'd150;
    localparam logic [GAIN_W-1:0] GAIN_I_RST        = 10'd125;
    localparam logic [GAIN_W-1:0] GAIN_D_RST        = 10'd25;
    localparam logic [15:0]       SPEED_SCALE_RST   = 16'd921;
    localparam logic [MASK_W-1:0] POLARITY_MASK_RST = 4'd11;
    localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST    = 16'd65535;
    localparam logic [DUTY_W-1:0] BRAKE_LEVEL_RST   = 16'd1000;

endpackage

`default_nettype wire

// ----- rtl/wspd_cfg.sv -----
// Configuration register file: gains, speed scale, polarity, duty limit, brake level.
// Depends on wspd_pkg.
`default_nettype none

module wspd_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wspd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wspd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output wspd_pkg::cfg_regs_t                   regs
);
    import wspd_pkg::*;

    cfg_regs_t regs_reg;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.gain_p        <= GAIN_P_RST;
            regs_reg.gain_i        <= GAIN_I_RST;
            regs_reg.gain_d        <= GAIN_D_RST;
            regs_reg.speed_scale   <= SPEED_SCALE_RST;
            regs_reg.polarity_mask <= POLARITY_MASK_RST;
            regs_reg.duty_limit    <= DUTY_LIMIT_RST;
            regs_reg.brake_level   <= BRAKE_LEVEL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAIN_P:        regs_reg.gain_p        <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:        regs_reg.gain_i        <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:        regs_reg.gain_d        <= cfg_data[GAIN_W-1:0];
                CFG_SPEED_SCALE:   regs_reg.speed_scale   <= cfg_data;
                CFG_POLARITY_MASK: regs_reg.polarity_mask <= cfg_data[MASK_W-1:0];
                CFG_DUTY_LIMIT:    regs_reg.duty_limit    <= cfg_data;
                CFG_BRAKE_LEVEL:   regs_reg.brake_level   <= cfg_data;
                default:           ;  // drop writes to unused indexes
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wspd_mul.sv -----
// Shared signed-by-unsigned multiplier with a registered product.
// Depends on wspd_pkg.
`default_nettype none

module wspd_mul (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [wspd_pkg::OPA_W-1:0]  op_a,
    input  wire logic        [wspd_pkg::OPB_W-1:0]  op_b,
    output logic signed [wspd_pkg::PROD_W-1:0]      prod
);
    import wspd_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [OPB_W:0]    op_b_s;

    assign op_b_s = $signed({1'b0, op_b});
    assign prod   = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b_s);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wheel_speed_pid_drive_top.sv -----
// Per-wheel speed loop: scale encoder delta, positional PID, PWM split.
// Depends on wspd_pkg, wspd_cfg and wspd_mul.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tuser: action; tdata: wheel, encoder_count, target_speed
//  m_*      out  m_tvalid/m_tready   tdata: wheel_out, forward_duty, reverse_duty
//  cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A control update steps through MUL_SPEED, ERROR, MUL_P, MUL_I, MUL_D, ACC and
// DONE: four passes through the one shared multiplier (speed scale, P, I, D), the
// error step after the first, and the products summed as they arrive; the result
// register loads in DONE. A brake or an absent wheel goes from IDLE to DONE.
// Reset clears gains to defaults and all per-wheel PID state to zero.
// The result register frees the input side: a new beat is taken while the
// previous result waits on m_tready; a finished item waits only if it is full.
`default_nettype none

module wheel_speed_pid_drive_top #(
    parameter int WHEEL_COUNT = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [39:0]                        s_tdata,   // wheel, encoder_count, target_speed
    input  wire logic                               s_tuser,   // action
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [39:0]                             m_tdata,   // wheel_out, forward_duty, reverse_duty
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [wspd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [wspd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import wspd_pkg::*;

    localparam int STORE_DEPTH = (WHEEL_COUNT < 4) ? WHEEL_COUNT : 4;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [4:0] WHEEL_LIM = 5'(WHEEL_COUNT);
    localparam int MAG_W       = PROD_W - FRAC_SH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_SPEED,
        ST_ERROR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_DONE
    } state_t;

    cfg_regs_t cfg;

    state_t                    state_reg;
    logic                      run_reg;
    logic [WHEEL_W-1:0]        wheel_reg;
    logic [CNT_W-1:0]          count_reg;
    logic signed [SPD_W-1:0]   target_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [PROD_W-1:0]  acc_reg;
    logic [DUTY_W-1:0]         fwd_reg;
    logic [DUTY_W-1:0]         rev_reg;
    logic                      m_valid_reg;
    logic [39:0]               m_data_reg;

    logic signed [SUM_W-1:0]   sum_mem [STORE_DEPTH];
    logic signed [ERR_W-1:0]   prev_mem [STORE_DEPTH];

    logic                      mul_en;
    logic signed [OPA_W-1:0]   op_a;
    logic [OPB_W-1:0]          op_b;
    logic signed [PROD_W-1:0]  prod;

    logic [IDX_W-1:0]          idx;
    logic                      in_fire;
    logic                      in_wheel_ok;
    logic                      out_load;

    logic                      prod_neg;
    logic [PROD_W-1:0]         prod_mag;
    logic [MAG_W-1:0]          spd_mag;
    logic signed [SPD_W-1:0]   speed_sat;
    logic signed [SPD_W-1:0]   speed_val;
    logic signed [ERR_W-1:0]   err_val;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_val;
    logic signed [DIFF_W-1:0]  diff_val;

    logic [PROD_W-1:0]         acc_mag;
    logic [MAG_W-1:0]          duty_mag;
    logic [DUTY_W-1:0]         duty_sat;
    logic [DUTY_W-1:0]         fwd_out;
    logic [DUTY_W-1:0]         rev_out;

    wspd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    wspd_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign idx         = wheel_reg[IDX_W-1:0];
    assign s_tready    = (state_reg == ST_IDLE);
    assign in_fire     = s_tvalid && s_tready;
    assign in_wheel_ok = {3'b000, s_tdata[1:0]} < WHEEL_LIM;
    assign out_load    = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = m_data_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_en = 1'b1;
        op_a   = '0;
        op_b   = '0;
        unique case (state_reg)
            ST_MUL_SPEED:
            begin
                op_a = OPA_W'($signed(count_reg));
                op_b = cfg.speed_scale;
            end
            ST_MUL_P:
            begin
                op_a = OPA_W'(err_reg);
                op_b = OPB_W'(cfg.gain_p);
            end
            ST_MUL_I:
            begin
                op_a = OPA_W'(sum_reg);
                op_b = OPB_W'(cfg.gain_i);
            end
            ST_MUL_D:
            begin
                op_a = OPA_W'(diff_reg);
                op_b = OPB_W'(cfg.gain_d);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // speed saturation, polarity, error, integral and error difference
    always_comb
    begin
        prod_neg = prod[PROD_W-1];
        prod_mag = prod_neg ? PROD_W'(0) - PROD_W'(prod) : PROD_W'(prod);
        spd_mag  = prod_mag[PROD_W-1:FRAC_SH];
        if (prod_neg)
        begin
            speed_sat = (spd_mag > MAG_W'(32768)) ? 16'sh8000
                                                  : $signed(16'd0 - spd_mag[SPD_W-1:0]);
        end
        else
        begin
            speed_sat = (spd_mag > MAG_W'(32767)) ? 16'sh7FFF
                                                  : $signed(spd_mag[SPD_W-1:0]);
        end
        if (cfg.polarity_mask[wheel_reg])
        begin
            speed_val = (speed_sat == 16'sh8000) ? 16'sh7FFF : -speed_sat;
        end
        else
        begin
            speed_val = speed_sat;
        end
        err_val  = ERR_W'(target_reg) - ERR_W'(speed_val);
        sum_wide = (SUM_W + 1)'(sum_mem[idx]) + (SUM_W + 1)'(err_val);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_val = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_val = sum_wide[SUM_W-1:0];
        end
        diff_val = DIFF_W'(err_val) - DIFF_W'(prev_mem[idx]);
    end

    // duty magnitude from the sum, clipped to the limit, split by sign; else the stored levels
    always_comb
    begin
        acc_mag  = acc_reg[PROD_W-1] ? PROD_W'(0) - PROD_W'(acc_reg) : PROD_W'(acc_reg);
        duty_mag = acc_mag[PROD_W-1:FRAC_SH];
        duty_sat = (duty_mag > MAG_W'(cfg.duty_limit)) ? cfg.duty_limit
                                                       : duty_mag[DUTY_W-1:0];
        if (!run_reg)
        begin
            fwd_out = fwd_reg;
            rev_out = rev_reg;
        end
        else if (acc_reg[PROD_W-1])
        begin
            fwd_out = '0;
            rev_out = duty_sat;
        end
        else
        begin
            fwd_out = duty_sat;
            rev_out = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                sum_mem[i]  <= '0;
                prev_mem[i] <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {6'd0, rev_out, fwd_out, wheel_reg};
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        run_reg    <= !s_tuser && in_wheel_ok;
                        wheel_reg  <= s_tdata[1:0];
                        count_reg  <= s_tdata[17:2];
                        target_reg <= $signed(s_tdata[33:18]);
                        fwd_reg    <= s_tuser ? cfg.brake_level : '0;
                        rev_reg    <= s_tuser ? cfg.brake_level : '0;
                        // brake and absent wheels skip the loop entirely
                        state_reg  <= (s_tuser || !in_wheel_ok) ? ST_DONE : ST_MUL_SPEED;
                    end
                end
                ST_MUL_SPEED:
                begin
                    state_reg <= ST_ERROR;
                end
                ST_ERROR:
                begin
                    err_reg   <= err_val;
                    sum_reg   <= sum_val;
                    diff_reg  <= diff_val;
                    state_reg <= ST_MUL_P;
                end
                ST_MUL_P:
                begin
                    state_reg <= ST_MUL_I;
                end
                ST_MUL_I:
                begin
                    acc_reg   <= prod;
                    state_reg <= ST_MUL_D;
                end
                ST_MUL_D:
                begin
                    acc_reg   <= acc_reg + prod;
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    acc_reg   <= acc_reg + prod;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        if (run_reg)
                        begin
                            sum_mem[idx]  <= sum_reg;
                            prev_mem[idx] <= err_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != ST_IDLE)
        else $error("accepted beat left the sequencer idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load && run_reg |-> (fwd_out == '0) || (rev_out == '0))
        else $error("both drive channels active on a control update");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load && run_reg |-> fwd_out <= cfg.duty_limit && rev_out <= cfg.duty_limit)
        else $error("duty above limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && !out_load |=> state_reg == ST_DONE)
        else $error("finished item dropped while result register full");

endmodule

`default_nettype wire

// ----- tb/wheel_speed_pid_drive_top_tb.sv -----
// Self-checking bench for wheel_speed_pid_drive_top: directed rows, integral wind-up, random.
// Drive results are predicted in-bench per wheel and compared beat by beat.
// Depends on wspd_pkg and the top-level RTL only.
`default_nettype none

module wheel_speed_pid_drive_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wspd_pkg::*;

    localparam int      WHEELS          = 4;
    localparam int      DRAIN_CYCLES    = 30;
    localparam int      WATCHDOG_LIMIT  = 5000;
    localparam int      REPORT_CAP      = 100;
    localparam int      WINDUP_STEPS    = 50;
    localparam int      RAND_SEGMENTS   = 8;
    localparam int      SEGMENT_ITEMS   = 135;
    localparam int      CFG_UNUSED_IDX  = 7;
    localparam longint  SUM_MAX         = 64'sd2147483647;
    localparam longint  SUM_MIN         = -SUM_MAX - 1;
    localparam logic    ACT_UPDATE      = 1'b0;
    localparam logic    ACT_BRAKE       = 1'b1;

    typedef enum logic [2:0] {
        SET_RESET, SET_LIMIT0, SET_MAX, SET_ZERO, SET_WINDUP, SET_RANDOM
    } cfg_kind_t;

    // packed low field last, so the struct lines up with tdata bit 0 upward
    typedef struct packed {
        logic [DUTY_W-1:0]  rev;
        logic [DUTY_W-1:0]  fwd;
        logic [WHEEL_W-1:0] wheel;
    } drive_t;

    typedef struct packed {
        cfg_kind_t          kind;
        logic               act;
        logic [WHEEL_W-1:0] wheel;
        logic [15:0]        cnt;
        logic [15:0]        tgt;
        logic               typed;
        logic [15:0]        fwd;
        logic [15:0]        rev;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [39:0]            s_tdata = '0;      // wheel, encoder_count, target_speed
    logic                   s_tuser = 1'b0;    // action
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [39:0]            m_tdata;           // wheel_out, forward_duty, reverse_duty
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    cfg_regs_t              cfg_model;
    logic signed [SUM_W-1:0] err_sum  [WHEELS];
    logic signed [ERR_W-1:0] last_err [WHEELS];
    drive_t                 duty_due [$];
    dir_row_t               dir_rows [$];
    int                     src_idle_pct = 0;
    int                     snk_stall_pct = 0;
    int                     mismatch_count = 0;
    int                     quiet_cycles = 0;

    wheel_speed_pid_drive_top #(
        .WHEEL_COUNT (WHEELS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // One wheel step: speed from encoder delta, PID with clamped integral, duty split.
    function automatic drive_t pid_drive_step(input logic act, input logic [WHEEL_W-1:0] w,
                                              input logic [15:0] cnt, input logic [15:0] tgt);
        drive_t r;
        longint count_l, target_l, scale_l, gp, gi, gd, lim;
        longint prod, mag, speed, err, sum, raw;
        r.wheel = w;
        r.fwd = '0;
        r.rev = '0;
        if (act == ACT_BRAKE)
        begin
            r.fwd = cfg_model.brake_level;
            r.rev = cfg_model.brake_level;
        end
        else
        begin
            count_l  = longint'($signed(cnt));
            target_l = longint'($signed(tgt));
            scale_l  = longint'(cfg_model.speed_scale);
            gp       = longint'(cfg_model.gain_p);
            gi       = longint'(cfg_model.gain_i);
            gd       = longint'(cfg_model.gain_d);
            lim      = longint'(cfg_model.duty_limit);
            prod = count_l * scale_l;
            mag  = ((prod < 0) ? -prod : prod) >> FRAC_SH;
            if (prod < 0)
                speed = (mag > 32768) ? -32768 : -mag;
            else
                speed = (mag > 32767) ? 32767 : mag;
            if (cfg_model.polarity_mask[w])
                speed = (speed == -32768) ? 32767 : -speed;
            err = target_l - speed;
            sum = longint'(err_sum[w]) + err;
            if (sum > SUM_MAX)
                sum = SUM_MAX;
            else if (sum < SUM_MIN)
                sum = SUM_MIN;
            raw = err * gp + sum * gi + (err - longint'(last_err[w])) * gd;
            mag = ((raw < 0) ? -raw : raw) >> FRAC_SH;
            if (mag > lim)
                mag = lim;
            if (raw < 0)
                r.rev = mag[15:0];
            else
                r.fwd = mag[15:0];
            err_sum[w]  = sum[31:0];
            last_err[w] = err[16:0];
        end
        return r;
    endfunction

    // Register words, index order, for one named setting.
    function automatic logic [6:0][15:0] cfg_set(input cfg_kind_t kind);
        logic [6:0][15:0] v;
        v[CFG_GAIN_P]        = 16'(GAIN_P_RST);
        v[CFG_GAIN_I]        = 16'(GAIN_I_RST);
        v[CFG_GAIN_D]        = 16'(GAIN_D_RST);
        v[CFG_SPEED_SCALE]   = SPEED_SCALE_RST;
        v[CFG_POLARITY_MASK] = 16'(POLARITY_MASK_RST);
        v[CFG_DUTY_LIMIT]    = DUTY_LIMIT_RST;
        v[CFG_BRAKE_LEVEL]   = BRAKE_LEVEL_RST;
        case (kind)
            SET_LIMIT0:
            begin
                v[CFG_DUTY_LIMIT]  = 16'h0000;
                v[CFG_BRAKE_LEVEL] = 16'hFFFF;
            end
            SET_MAX:
            begin
                v = '1;
                v[CFG_BRAKE_LEVEL] = 16'h0000;
            end
            SET_ZERO:
                v = '0;
            SET_WINDUP:
            begin
                v[CFG_GAIN_P]        = 16'd1;
                v[CFG_GAIN_I]        = 16'd1;
                v[CFG_GAIN_D]        = 16'd1;
                v[CFG_SPEED_SCALE]   = 16'hFFFF;
                v[CFG_POLARITY_MASK] = 16'b0011;
            end
            SET_RANDOM:
            begin
                v[CFG_GAIN_P]        = 16'($urandom);
                v[CFG_GAIN_I]        = 16'($urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom);
                v[CFG_GAIN_D]        = 16'($urandom);
                v[CFG_SPEED_SCALE]   = 16'($urandom_range(0, 1) ? $urandom_range(0, 2047)
                                                                : $urandom);
                v[CFG_POLARITY_MASK] = 16'($urandom);
                v[CFG_DUTY_LIMIT]    = 16'($urandom_range(0, 1) ? $urandom : 16'hFFFF);
                v[CFG_BRAKE_LEVEL]   = 16'($urandom);
            end
            default: ;
        endcase
        return v;
    endfunction

    // Walk every register, then one stray index the block must ignore.
    task automatic load_config(input logic [6:0][15:0] vals);
        logic [15:0] word;
        for (int i = 0; i <= CFG_UNUSED_IDX; i++)
        begin
            word = (i == CFG_UNUSED_IDX) ? 16'($urandom) : vals[i];
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= word;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (cfg_idx_t'(i))
                CFG_GAIN_P:        cfg_model.gain_p        = word[GAIN_W-1:0];
                CFG_GAIN_I:        cfg_model.gain_i        = word[GAIN_W-1:0];
                CFG_GAIN_D:        cfg_model.gain_d        = word[GAIN_W-1:0];
                CFG_SPEED_SCALE:   cfg_model.speed_scale   = word;
                CFG_POLARITY_MASK: cfg_model.polarity_mask = word[MASK_W-1:0];
                CFG_DUTY_LIMIT:    cfg_model.duty_limit    = word;
                CFG_BRAKE_LEVEL:   cfg_model.brake_level   = word;
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Hold the input side until every pending drive beat has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (duty_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_sample(input logic act, input logic [WHEEL_W-1:0] w,
                               input logic [15:0] cnt, input logic [15:0] tgt,
                               input logic typed, input logic [15:0] fwd,
                               input logic [15:0] rev);
        drive_t want;
        want = pid_drive_step(act, w, cnt, tgt);
        if (typed)
        begin
            want.fwd = fwd;
            want.rev = rev;
        end
        duty_due.push_back(want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, tgt, cnt, w};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic add_row(input cfg_kind_t kind, input logic act, input logic [1:0] w,
                           input logic [15:0] cnt, input logic [15:0] tgt,
                           input logic typed, input logic [15:0] fwd, input logic [15:0] rev);
        dir_row_t row;
        row = '{kind, act, w, cnt, tgt, typed, fwd, rev};
        dir_rows.push_back(row);
    endtask

    // Mostly small deltas around zero, some full range, some rail values.
    function automatic logic [15:0] rand_word(input int span);
        int pick;
        int val;
        pick = $urandom_range(99);
        val  = $urandom_range(0, 2 * span);
        if (pick < 55)
            return 16'(val - span);
        else if (pick < 90)
            return 16'($urandom);
        case ($urandom_range(3))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    always @(posedge clk)
    begin : drive_monitor
        drive_t got;
        drive_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[33:0];
                if (duty_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP)
                        $error("unexpected drive beat, wheel_out %0d", got.wheel);
                end
                else
                begin
                    want = duty_due.pop_front();
                    // cap the report so a broken wind-up run stays readable
                    if (got.wheel != want.wheel)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_CAP)
                            $error("wheel_out expected %0d actual %0d", want.wheel, got.wheel);
                    end
                    if (got.fwd != want.fwd)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_CAP)
                            $error("forward_duty expected %0d actual %0d", want.fwd, got.fwd);
                    end
                    if (got.rev != want.rev)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_CAP)
                            $error("reverse_duty expected %0d actual %0d", want.rev, got.rev);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("wheel_speed_pid_drive_top_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        cfg_kind_t cur_kind;
        dir_row_t  row;
        logic      act;

        cfg_model.gain_p        = GAIN_P_RST;
        cfg_model.gain_i        = GAIN_I_RST;
        cfg_model.gain_d        = GAIN_D_RST;
        cfg_model.speed_scale   = SPEED_SCALE_RST;
        cfg_model.polarity_mask = POLARITY_MASK_RST;
        cfg_model.duty_limit    = DUTY_LIMIT_RST;
        cfg_model.brake_level   = BRAKE_LEVEL_RST;
        for (int w = 0; w < WHEELS; w++)
        begin
            err_sum[w]  = '0;
            last_err[w] = '0;
        end

        // reset defaults; wheel 0 on the negative rail exercises the negate clamp
        add_row(SET_RESET,  ACT_BRAKE,  2'd0, 16'h0000, 16'h0000, 1'b1, 16'd1000, 16'd1000);
        add_row(SET_RESET,  ACT_UPDATE, 2'd1, 16'h0000, 16'h0000, 1'b1, 16'd0, 16'd0);
        add_row(SET_RESET,  ACT_UPDATE, 2'd0, 16'h7FFF, 16'h7FFF, 1'b0, 16'd0, 16'd0);
        add_row(SET_RESET,  ACT_UPDATE, 2'd0, 16'h8000, 16'h8000, 1'b0, 16'd0, 16'd0);
        add_row(SET_RESET,  ACT_UPDATE, 2'd2, 16'h8000, 16'h7FFF, 1'b0, 16'd0, 16'd0);
        add_row(SET_RESET,  ACT_UPDATE, 2'd3, 16'h8000, 16'h8000, 1'b0, 16'd0, 16'd0);
        add_row(SET_RESET,  ACT_UPDATE, 2'd2, 16'hFFFF, 16'h0000, 1'b0, 16'd0, 16'd0);
        add_row(SET_RESET,  ACT_UPDATE, 2'd1, 16'h0001, 16'hFFFF, 1'b0, 16'd0, 16'd0);
        add_row(SET_RESET,  ACT_UPDATE, 2'd3, 16'h0123, 16'h0456, 1'b0, 16'd0, 16'd0);
        add_row(SET_RESET,  ACT_BRAKE,  2'd3, 16'hFFFF, 16'h8000, 1'b1, 16'd1000, 16'd1000);
        add_row(SET_RESET,  ACT_UPDATE, 2'd2, 16'h0000, 16'h0000, 1'b0, 16'd0, 16'd0);
        // zero duty limit forces both update channels low; a brake still gives the brake level
        add_row(SET_LIMIT0, ACT_UPDATE, 2'd0, 16'h7FFF, 16'h8000, 1'b1, 16'd0, 16'd0);
        add_row(SET_LIMIT0, ACT_UPDATE, 2'd1, 16'h8000, 16'h7FFF, 1'b1, 16'd0, 16'd0);
        add_row(SET_LIMIT0, ACT_UPDATE, 2'd3, 16'h5555, 16'hAAAA, 1'b1, 16'd0, 16'd0);
        add_row(SET_LIMIT0, ACT_BRAKE,  2'd2, 16'hAAAA, 16'h5555, 1'b1, 16'hFFFF, 16'hFFFF);
        add_row(SET_MAX,    ACT_BRAKE,  2'd1, 16'h7FFF, 16'h7FFF, 1'b1, 16'd0, 16'd0);
        add_row(SET_MAX,    ACT_UPDATE, 2'd0, 16'h8000, 16'h7FFF, 1'b0, 16'd0, 16'd0);
        add_row(SET_MAX,    ACT_UPDATE, 2'd1, 16'h7FFF, 16'h8000, 1'b0, 16'd0, 16'd0);
        add_row(SET_MAX,    ACT_UPDATE, 2'd2, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 16'd0);
        add_row(SET_MAX,    ACT_UPDATE, 2'd3, 16'h8000, 16'h8000, 1'b0, 16'd0, 16'd0);
        add_row(SET_MAX,    ACT_UPDATE, 2'd3, 16'h0001, 16'h0000, 1'b0, 16'd0, 16'd0);
        add_row(SET_ZERO,   ACT_UPDATE, 2'd2, 16'h7FFF, 16'h8000, 1'b1, 16'd0, 16'd0);
        add_row(SET_ZERO,   ACT_BRAKE,  2'd0, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0, 16'd0);

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_kind = SET_RESET;
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind != cur_kind)
            begin
                wait_drained();
                load_config(cfg_set(row.kind));
                cur_kind = row.kind;
            end
            push_sample(row.act, row.wheel, row.cnt, row.tgt, row.typed, row.fwd, row.rev);
        end

        // Push the integral of wheel 2 up and wheel 3 down with the largest error each step.
        wait_drained();
        load_config(cfg_set(SET_WINDUP));
        for (int k = 0; k < WINDUP_STEPS; k++)
        begin
            push_sample(ACT_UPDATE, 2'd2, 16'h8000, 16'h7FFF, 1'b0, 16'd0, 16'd0);
            push_sample(ACT_UPDATE, 2'd3, 16'h7FFF, 16'h8000, 1'b0, 16'd0, 16'd0);
        end

        for (int seg = 0; seg < RAND_SEGMENTS; seg++)
        begin
            wait_drained();
            case (seg)
                0:       load_config(cfg_set(SET_RESET));
                2:       load_config(cfg_set(SET_MAX));
                4:       load_config(cfg_set(SET_ZERO));
                6:       load_config(cfg_set(SET_LIMIT0));
                default: load_config(cfg_set(SET_RANDOM));
            endcase
            case (seg % 4)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 50;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 50;
                end
                default:
                begin
                    src_idle_pct  = 29;
                    snk_stall_pct = 29;
                end
            endcase
            for (int k = 0; k < SEGMENT_ITEMS; k++)
            begin
                if ((seg == 1 && k == 75) || $urandom_range(99) < 2)
                    wait_drained();
                act = ($urandom_range(99) < 12) ? ACT_BRAKE : ACT_UPDATE;
                push_sample(act, WHEEL_W'($urandom_range(0, WHEELS - 1)), rand_word(2000),
                            rand_word(8000), 1'b0, 16'd0, 16'd0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && duty_due.size() == 0)
            $display("wheel_speed_pid_drive_top_tb: PASS");
        else
            $display("wheel_speed_pid_drive_top_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
